@@ hw/rtl/min_max_bellman_state_update_defines.svh @@
// Assertion macros for the Bellman update block
`ifndef MIN_MAX_BELLMAN_STATE_UPDATE_DEFINES_SVH
`define MIN_MAX_BELLMAN_STATE_UPDATE_DEFINES_SVH

// same-cycle implication
`define MMB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmb: same-cycle check failed");

// next-cycle implication
`define MMB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmb: next-cycle check failed");

`endif

@@ hw/rtl/mmb_pkg.sv @@
// Shared types and constants of the Bellman update block
package mmb_pkg;

    typedef enum logic [2:0] {
        OP_WRITE       = 3'd0,
        OP_BEGIN_STATE = 3'd1,
        OP_BEGIN_ROW   = 3'd2,
        OP_ENTRY       = 3'd3,
        OP_END_ROW     = 3'd4,
        OP_END_STATE   = 3'd5
    } op_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_WRITE,
        CMD_BEGIN_STATE,
        CMD_BEGIN_ROW,
        CMD_SELF_LOOP,
        CMD_READ,
        CMD_MUL_LO,
        CMD_MUL_HI,
        CMD_ACC,
        CMD_DIV_INIT,
        CMD_DIV_STEP,
        CMD_ROW_END,
        CMD_ROW_DIV,
        CMD_ROW_SKIP,
        CMD_REPORT
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       self_hit;
        logic       row_full;
        logic       need_div;
        logic       div_last;
    } status_t;

    localparam logic [32:0] PROB_ONE  = 33'h1_0000_0000;
    localparam logic [63:0] VAL_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [6:0]  DIV_STEPS = 7'd95;

endpackage

@@ hw/rtl/min_max_bellman_state_update.sv @@
// Top level of the min/max Bellman state update block
// Write, begin state, begin row, self-loop entry, end state and a non-dividing end row
// go through load and decode only; end state raises done on the cycle after decode.
// Other entries add a store read, two passes of one 33x33 multiplier and an accumulate.
// An end row that divides adds the bit-serial divider (96 steps).
// Reset clears all control state; the value store is not cleared. done cannot be stalled.
module min_max_bellman_state_update
    import mmb_pkg::*;
#(
    parameter int NUM_STATES  = 1024,
    parameter int MAX_CHOICES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         opcode,
    input  logic [9:0]         index,
    input  logic signed [63:0] value,
    input  logic [32:0]        probability,
    input  logic               fixed_choice,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data,
    output logic               done,
    output logic [9:0]         state_index,
    output logic signed [63:0] state_value,
    output logic [3:0]         choice,
    output logic               empty_group
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    mmb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mmb_datapath #(
        .NUM_STATES  (NUM_STATES),
        .MAX_CHOICES (MAX_CHOICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .index        (index),
        .value        (value),
        .probability  (probability),
        .fixed_choice (fixed_choice),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .done         (done),
        .state_index  (state_index),
        .state_value  (state_value),
        .choice       (choice),
        .empty_group  (empty_group)
    );

endmodule

@@ hw/rtl/mmb_ctrl.sv @@
// Sequencing state machine of the Bellman update block
module mmb_ctrl
    import mmb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_DIV,
        S_DIV_END
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                unique case (status.op)
                    OP_WRITE:       cmd = CMD_WRITE;
                    OP_BEGIN_STATE: cmd = CMD_BEGIN_STATE;
                    OP_BEGIN_ROW:   cmd = CMD_BEGIN_ROW;
                    OP_ENTRY:
                    begin
                        if (status.self_hit)
                        begin
                            cmd = CMD_SELF_LOOP;
                        end
                        else
                        begin
                            cmd        = CMD_READ;
                            state_next = S_MUL_LO;
                        end
                    end
                    OP_END_ROW:
                    begin
                        priority if (status.row_full)
                        begin
                            cmd = CMD_ROW_SKIP;
                        end
                        else if (status.need_div)
                        begin
                            cmd        = CMD_DIV_INIT;
                            state_next = S_DIV;
                        end
                        else
                        begin
                            cmd = CMD_ROW_END;
                        end
                    end
                    OP_END_STATE:   cmd = CMD_REPORT;
                    default:        cmd = CMD_NONE;
                endcase
            end
            S_MUL_LO:
            begin
                cmd        = CMD_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd        = CMD_MUL_HI;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd        = CMD_ACC;
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                cmd = CMD_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                cmd        = CMD_ROW_DIV;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ hw/rtl/mmb_datapath.sv @@
// Value store, multiply-accumulate, divider and best-row tracking
module mmb_datapath
    import mmb_pkg::*;
#(
    parameter int NUM_STATES  = 1024,
    parameter int MAX_CHOICES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [2:0]         opcode,
    input  logic [9:0]         index,
    input  logic signed [63:0] value,
    input  logic [32:0]        probability,
    input  logic               fixed_choice,
    input  logic               cfg_valid,
    input  logic               cfg_data,
    output logic               done,
    output logic [9:0]         state_index,
    output logic signed [63:0] state_value,
    output logic [3:0]         choice,
    output logic               empty_group
);

    localparam int IW  = $clog2(NUM_STATES);
    localparam int RNW = $clog2(MAX_CHOICES + 1);
    localparam logic [27:0] NS_W = 28'(NUM_STATES);

    logic [2:0]  op_reg;
    logic [IW-1:0] idx_reg;
    logic [63:0] val_reg;
    logic [32:0] prob_reg;
    logic        fc_reg;

    logic [63:0] store_mem [NUM_STATES];
    logic [63:0] rdata_reg;

    logic          minimize_reg;
    logic [IW-1:0] target_reg;
    logic          fixed_reg;
    logic [63:0]   row_sum_reg;
    logic          self_seen_reg;
    logic [32:0]   loop_rem_reg;
    logic [63:0]   best_reg;
    logic [RNW-1:0] best_choice_reg;
    logic          have_best_reg;
    logic [RNW-1:0] row_num_reg;

    logic [32:0] lo_reg;
    logic [63:0] hi_reg;

    logic        neg_reg;
    logic [95:0] dvd_reg;
    logic [32:0] prem_reg;
    logic [62:0] quot_reg;
    logic        ovf_reg;
    logic [6:0]  cnt_reg;

    logic        done_reg;
    logic [IW-1:0] out_idx_reg;
    logic [63:0] out_val_reg;
    logic [RNW-1:0] out_choice_reg;
    logic        out_empty_reg;

    // index reduction modulo the store depth
    logic [27:0]   red;
    logic [IW-1:0] idx_in;
    always_comb
    begin
        red = {18'd0, index};
        for (int k = 9; k >= 0; k--)
        begin
            if (red >= (NS_W << k))
            begin
                red = red - (NS_W << k);
            end
        end
        idx_in = red[IW-1:0];
    end

    // shared multiplier
    logic signed [32:0] mul_x;
    logic signed [66:0] mul_p;
    assign mul_x = (cmd == CMD_MUL_LO) ? $signed({1'b0, rdata_reg[31:0]})
                                       : $signed({rdata_reg[63], rdata_reg[63:32]});
    assign mul_p = $signed({1'b0, prob_reg}) * mul_x;

    // saturating accumulate
    logic [63:0] term;
    logic [64:0] acc_w;
    logic [63:0] acc_sat;
    assign term  = hi_reg + {31'd0, lo_reg};
    assign acc_w = {row_sum_reg[63], row_sum_reg} + {term[63], term};
    assign acc_sat = (acc_w[64] != acc_w[63]) ? (acc_w[64] ? VAL_MIN : VAL_MAX) : acc_w[63:0];

    // divider step
    logic [33:0] shifted;
    logic        qbit;
    logic [33:0] prem_new;
    assign shifted  = {prem_reg, dvd_reg[95]};
    assign qbit     = (shifted >= {1'b0, loop_rem_reg});
    assign prem_new = qbit ? (shifted - {1'b0, loop_rem_reg}) : shifted;

    logic [63:0] q64;
    logic [63:0] rv_div;
    assign q64    = {1'b0, quot_reg};
    assign rv_div = ovf_reg ? (neg_reg ? VAL_MIN : VAL_MAX)
                            : (neg_reg ? (64'd0 - q64) : q64);

    // row competition
    logic [63:0] rv;
    logic        usable;
    logic        better;
    assign rv     = (cmd == CMD_ROW_DIV) ? rv_div : row_sum_reg;
    assign usable = (cmd == CMD_ROW_DIV) || fixed_reg ||
                    !(self_seen_reg && (loop_rem_reg == 33'd0));
    assign better = minimize_reg ? ($signed(rv) < $signed(best_reg))
                                 : ($signed(rv) > $signed(best_reg));

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_WRITE)
        begin
            store_mem[idx_reg] <= val_reg;
        end
        else if ((cmd == CMD_REPORT) && have_best_reg)
        begin
            store_mem[target_reg] <= best_reg;
        end
        if (cmd == CMD_READ)
        begin
            rdata_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            op_reg   <= opcode;
            idx_reg  <= idx_in;
            val_reg  <= value;
            prob_reg <= probability[32] ? PROB_ONE : probability;
            fc_reg   <= fixed_choice;
        end
        if (cmd == CMD_MUL_LO)
        begin
            lo_reg <= mul_p[64:32];
        end
        if (cmd == CMD_MUL_HI)
        begin
            hi_reg <= mul_p[63:0];
        end
        if (cmd == CMD_DIV_INIT)
        begin
            neg_reg  <= row_sum_reg[63];
            dvd_reg  <= {(row_sum_reg[63] ? (64'd0 - row_sum_reg) : row_sum_reg), 32'd0};
            prem_reg <= '0;
            quot_reg <= '0;
            ovf_reg  <= 1'b0;
            cnt_reg  <= DIV_STEPS;
        end
        else if (cmd == CMD_DIV_STEP)
        begin
            dvd_reg  <= {dvd_reg[94:0], 1'b0};
            prem_reg <= prem_new[32:0];
            quot_reg <= {quot_reg[61:0], qbit};
            ovf_reg  <= ovf_reg | quot_reg[62];
            cnt_reg  <= cnt_reg - 7'd1;
        end
        if (cmd == CMD_REPORT)
        begin
            out_idx_reg    <= target_reg;
            out_val_reg    <= have_best_reg ? best_reg : 64'd0;
            out_choice_reg <= (have_best_reg && !fixed_reg) ? best_choice_reg : '0;
            out_empty_reg  <= !have_best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minimize_reg    <= 1'b0;
            target_reg      <= '0;
            fixed_reg       <= 1'b0;
            row_sum_reg     <= '0;
            self_seen_reg   <= 1'b0;
            loop_rem_reg    <= '0;
            best_reg        <= '0;
            best_choice_reg <= '0;
            have_best_reg   <= 1'b0;
            row_num_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd == CMD_REPORT);
            if (cfg_valid)
            begin
                minimize_reg <= cfg_data;
            end
            unique case (cmd)
                CMD_BEGIN_STATE:
                begin
                    target_reg      <= idx_reg;
                    fixed_reg       <= fc_reg;
                    row_sum_reg     <= '0;
                    self_seen_reg   <= 1'b0;
                    loop_rem_reg    <= '0;
                    best_reg        <= '0;
                    best_choice_reg <= '0;
                    have_best_reg   <= 1'b0;
                    row_num_reg     <= '0;
                end
                CMD_BEGIN_ROW:
                begin
                    row_sum_reg   <= val_reg;
                    self_seen_reg <= 1'b0;
                    loop_rem_reg  <= '0;
                end
                CMD_SELF_LOOP:
                begin
                    self_seen_reg <= 1'b1;
                    loop_rem_reg  <= PROB_ONE - prob_reg;
                end
                CMD_ACC:
                begin
                    row_sum_reg <= acc_sat;
                end
                CMD_ROW_END, CMD_ROW_DIV:
                begin
                    if (usable)
                    begin
                        if (fixed_reg)
                        begin
                            best_reg        <= rv;
                            best_choice_reg <= '0;
                            have_best_reg   <= 1'b1;
                        end
                        else if (!have_best_reg || better)
                        begin
                            best_reg        <= rv;
                            best_choice_reg <= row_num_reg;
                            have_best_reg   <= 1'b1;
                        end
                    end
                    row_num_reg   <= row_num_reg + RNW'(1);
                    row_sum_reg   <= '0;
                    self_seen_reg <= 1'b0;
                    loop_rem_reg  <= '0;
                end
                CMD_ROW_SKIP:
                begin
                    row_sum_reg   <= '0;
                    self_seen_reg <= 1'b0;
                    loop_rem_reg  <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.op       = op_reg;
    assign status.self_hit = (idx_reg == target_reg);
    assign status.row_full = (row_num_reg == RNW'(MAX_CHOICES));
    assign status.need_div = self_seen_reg && (loop_rem_reg != 33'd0);
    assign status.div_last = (cnt_reg == 7'd0);

    logic [IW+9:0]  idx_w;
    logic [RNW+3:0] ch_w;
    assign idx_w = {10'd0, out_idx_reg};
    assign ch_w  = {4'd0, out_choice_reg};

    assign done        = done_reg;
    assign state_index = idx_w[9:0];
    assign state_value = out_val_reg;
    assign choice      = ch_w[3:0];
    assign empty_group = out_empty_reg;

endmodule

@@ hw/rtl/mmb_checker.sv @@
// Port-level checks of the Bellman update block and their binding
`include "min_max_bellman_state_update_defines.svh"

module mmb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [63:0] state_value,
    input logic [3:0]  choice,
    input logic        empty_group
);

    `MMB_ASSERT_SAME(a_done_idle, clk, rst_n, done, !busy)
    `MMB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `MMB_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `MMB_ASSERT_SAME(a_empty_zero, clk, rst_n, done && empty_group,
        (state_value == 64'd0) && (choice == 4'd0))

endmodule

bind min_max_bellman_state_update mmb_checker u_mmb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .state_value (state_value),
    .choice      (choice),
    .empty_group (empty_group)
);
